// File: rtl/core/branch_target_buffer_predictor_defines.svh
// Assertion macros for the branch target buffer checker file.
`ifndef BRANCH_TARGET_BUFFER_PREDICTOR_DEFINES_SVH
`define BRANCH_TARGET_BUFFER_PREDICTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BTBP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("btbp assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BTBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("btbp assertion failed");

`endif

// File: rtl/core/btbp_pkg.sv
// Types, constants and prediction update for the branch target buffer.
package btbp_pkg;

   localparam int ADDR_W = 32;
   localparam int PRED_W = 2;

   localparam logic [1:0] MODE_A       = 2'd0;
   localparam logic [1:0] MODE_B       = 2'd1;
   localparam logic [1:0] MODE_CLASSIC = 2'd2;

   localparam logic [PRED_W-1:0] PRED_TAKEN      = 2'b00;
   localparam logic [PRED_W-1:0] PRED_WEAK_TAKEN = 2'b01;
   localparam logic [PRED_W-1:0] PRED_WEAK_NOT   = 2'b10;
   localparam logic [PRED_W-1:0] PRED_NOT        = 2'b11;

   localparam logic [ADDR_W-1:0] PC_STEP = 32'd4;

   typedef logic [PRED_W-1:0] pred_type [4];

   // next state tables indexed by the old prediction
   localparam pred_type TK_A = '{PRED_TAKEN, PRED_TAKEN, PRED_WEAK_TAKEN, PRED_WEAK_NOT};
   localparam pred_type NT_A = '{PRED_WEAK_TAKEN, PRED_NOT, PRED_NOT, PRED_NOT};
   localparam pred_type TK_B = '{PRED_TAKEN, PRED_TAKEN, PRED_TAKEN, PRED_WEAK_NOT};
   localparam pred_type NT_B = '{PRED_WEAK_TAKEN, PRED_WEAK_NOT, PRED_NOT, PRED_NOT};
   localparam pred_type TK_C = '{PRED_TAKEN, PRED_TAKEN, PRED_WEAK_TAKEN, PRED_WEAK_NOT};
   localparam pred_type NT_C = '{PRED_WEAK_TAKEN, PRED_WEAK_NOT, PRED_NOT, PRED_NOT};

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [ADDR_W-1:0] target;
      logic [PRED_W-1:0] pred;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic [PRED_W-1:0] next_pred(input logic [1:0] mode,
                                                   input logic [PRED_W-1:0] old,
                                                   input logic went_taken);
      logic [PRED_W-1:0] res;
      case (mode)
         MODE_A:  res = went_taken ? TK_A[old] : NT_A[old];
         MODE_B:  res = went_taken ? TK_B[old] : NT_B[old];
         default: res = went_taken ? TK_C[old] : NT_C[old];
      endcase
      return res;
   endfunction

endpackage

// File: rtl/core/branch_target_buffer_predictor.sv
// Direct-mapped branch target buffer with selectable 2-bit direction predictor.
// An accepted request reads the entry RAM (registered) and is resolved in ST_LOOKUP; no
// new request is taken until the result register loads and any write back is done.
// Reset: synchronous; mode_ff returns to 2, and a clearing pass zeroes every entry
// of the entry RAM, with req_stall high throughout.
// ENTRIES must be a power of two.
module branch_target_buffer_predictor
   import btbp_pkg::*;
#(
   parameter int ENTRIES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ADDR_W-1:0]   req_current_pc,
   input  logic [ADDR_W-1:0]   req_next_pc,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit,
   output logic                rsp_predicted_taken,
   output logic                rsp_correct,
   output logic                rsp_wrong_target,
   output logic                rsp_taken,
   output logic                rsp_installed,
   output logic                rsp_collision,
   output logic [PRED_W-1:0]   rsp_prediction_after,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_wr_data
);

   localparam int INDEX_W = $clog2(ENTRIES);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOKUP} state_type;

   state_type           state_ff, state_in;
   logic [INDEX_W-1:0]  clr_idx_ff, clr_idx_in;
   logic [1:0]          mode_ff, mode_in;
   logic [ADDR_W-1:0]   cur_ff, cur_in;
   logic [ADDR_W-1:0]   nxt_ff, nxt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                hit_ff, hit_in;
   logic                pt_ff, pt_in;
   logic                corr_ff, corr_in;
   logic                wt_ff, wt_in;
   logic                tk_ff, tk_in;
   logic                inst_ff, inst_in;
   logic                coll_ff, coll_in;
   logic [PRED_W-1:0]   pred_after_ff, pred_after_in;

   logic                accept;
   logic                done;
   logic                rd_en;
   logic [INDEX_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0]  rd_data;
   entry_type           rd_entry;
   logic                wr_en;
   logic [INDEX_W-1:0]  wr_addr;
   entry_type           wr_entry;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rd_en     = accept;
   assign rd_addr   = req_current_pc[INDEX_W+1:2];
   assign rd_entry  = entry_type'(rd_data);
   assign done      = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || !rsp_stall);

   btbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_W'(wr_entry)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      logic [ADDR_W-1:0] seq;
      logic              occupied;
      logic              hit;
      logic              pt;
      logic              corr;
      logic              wt;
      logic              tk;
      logic              inst;
      logic [ADDR_W-1:0] new_target;
      logic [PRED_W-1:0] new_pred;

      seq        = cur_ff + PC_STEP;
      occupied   = (rd_entry.address != '0);
      hit        = occupied && (rd_entry.address == cur_ff);
      pt         = hit && !rd_entry.pred[1];
      corr       = 1'b0;
      wt         = 1'b0;
      tk         = 1'b0;
      inst       = 1'b0;
      new_target = rd_entry.target;
      new_pred   = rd_entry.pred;

      if (hit) begin
         if (pt) begin
            if (nxt_ff == rd_entry.target) begin
               corr = 1'b1;
               tk   = 1'b1;
            end else if (nxt_ff != seq) begin
               wt         = 1'b1;
               tk         = 1'b1;
               new_target = nxt_ff;
            end
         end else begin
            corr = (nxt_ff == seq);
            tk   = (nxt_ff != seq);
         end
         new_pred = next_pred(mode_ff, rd_entry.pred, tk);
      end else if (nxt_ff != seq) begin
         inst       = 1'b1;
         tk         = 1'b1;
         new_target = nxt_ff;
         new_pred   = (mode_ff == MODE_B) ? PRED_WEAK_TAKEN : PRED_TAKEN;
      end

      // memory write: clearing sweep, or write back of a finished lookup that hit or installed
      wr_en            = 1'b0;
      wr_addr          = cur_ff[INDEX_W+1:2];
      wr_entry.address = cur_ff;
      wr_entry.target  = new_target;
      wr_entry.pred    = new_pred;
      if (state_ff == ST_CLEAR) begin
         wr_en    = 1'b1;
         wr_addr  = clr_idx_ff;
         wr_entry = '0;
      end else if (done && (hit || inst)) begin
         wr_en = 1'b1;
      end

      // next state
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == INDEX_W'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase

      mode_in = csr_wr_en ? csr_wr_data : mode_ff;
      cur_in  = accept ? req_current_pc : cur_ff;
      nxt_in  = accept ? req_next_pc : nxt_ff;

      // result register: load on finish, drop on transfer, hold while stalled
      rsp_valid_in  = rsp_valid_ff;
      hit_in        = hit_ff;
      pt_in         = pt_ff;
      corr_in       = corr_ff;
      wt_in         = wt_ff;
      tk_in         = tk_ff;
      inst_in       = inst_ff;
      coll_in       = coll_ff;
      pred_after_in = pred_after_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         rsp_valid_in  = 1'b1;
         hit_in        = hit;
         pt_in         = pt;
         corr_in       = corr;
         wt_in         = wt;
         tk_in         = tk;
         inst_in       = inst;
         coll_in       = inst && occupied;
         pred_after_in = new_pred;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         mode_ff      <= MODE_CLASSIC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      hit_ff        <= hit_in;
      pt_ff         <= pt_in;
      corr_ff       <= corr_in;
      wt_ff         <= wt_in;
      tk_ff         <= tk_in;
      inst_ff       <= inst_in;
      coll_ff       <= coll_in;
      pred_after_ff <= pred_after_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = hit_ff;
   assign rsp_predicted_taken  = pt_ff;
   assign rsp_correct          = corr_ff;
   assign rsp_wrong_target     = wt_ff;
   assign rsp_taken            = tk_ff;
   assign rsp_installed        = inst_ff;
   assign rsp_collision        = coll_ff;
   assign rsp_prediction_after = pred_after_ff;

endmodule

// File: rtl/core/btbp_ram.sv
// Generic single write port, single read port RAM with registered read.
module btbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/btbp_checker.sv
// Port-level checks for the branch target buffer, bound to the top level.
`include "branch_target_buffer_predictor_defines.svh"

module btbp_checker
   import btbp_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_hit,
   input logic              rsp_predicted_taken,
   input logic              rsp_correct,
   input logic              rsp_wrong_target,
   input logic              rsp_taken,
   input logic              rsp_installed,
   input logic              rsp_collision,
   input logic [PRED_W-1:0] rsp_prediction_after
);

   // a stalled result stays valid and keeps its hit, taken and prediction fields
   `BTBP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_hit) && $stable(rsp_taken) && $stable(rsp_prediction_after))

   `BTBP_ASSERT_NOW(a_install_on_miss, clock, reset, rsp_valid && rsp_installed, !rsp_hit && rsp_taken && !rsp_correct && !rsp_predicted_taken)

   `BTBP_ASSERT_NOW(a_collision_needs_install, clock, reset, rsp_valid && rsp_collision, rsp_installed)

   `BTBP_ASSERT_NOW(a_wrong_target_on_taken_hit, clock, reset, rsp_valid && rsp_wrong_target, rsp_hit && rsp_predicted_taken && rsp_taken && !rsp_correct)

endmodule

bind branch_target_buffer_predictor btbp_checker u_btbp_checker (.*);

// File: test/tb_branch_target_buffer_predictor.sv
// Testbench for the branch target buffer: directed table, then random branch streams per mode.
module tb_branch_target_buffer_predictor;
   import btbp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH           = 1024;
   localparam int unsigned RESET_CYCLES    = 11;
   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned ITEMS_PER_PHASE = 150;
   localparam int unsigned HOLD_AFTER      = 300;
   localparam int unsigned HOLD_CYCLES     = 300;
   localparam int unsigned DRAIN_CYCLES    = 8;
   localparam int unsigned POOL            = 16;
   localparam int unsigned REPORT_CAP      = 40;

   // mode value 3 is not assigned a machine; it falls back to the classic counter
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic              hit;
      logic              predicted_taken;
      logic              correct;
      logic              wrong_target;
      logic              taken;
      logic              installed;
      logic              collision;
      logic [PRED_W-1:0] prediction_after;
   } btb_outcome_type;

   typedef enum logic {ROW_PREDICT, ROW_FIXED} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [1:0]        mode;
      logic [ADDR_W-1:0] cur;
      logic [ADDR_W-1:0] nxt;
      btb_outcome_type   res;
   } plan_row_type;

   localparam btb_outcome_type SKIP_FALLTHRU = '0;
   localparam btb_outcome_type FRESH_INSTALL =
      '{taken: 1'b1, installed: 1'b1, default: '0};
   localparam btb_outcome_type EVICT_INSTALL =
      '{taken: 1'b1, installed: 1'b1, collision: 1'b1, default: '0};
   localparam btb_outcome_type WEAK_INSTALL =
      '{taken: 1'b1, installed: 1'b1, prediction_after: PRED_WEAK_TAKEN, default: '0};

   localparam plan_row_type DIRECTED_PLAN [25] = '{
      // empty store, sequential flow, then install and walk the counter
      '{ROW_FIXED,   MODE_CLASSIC, 32'h0000_0100, 32'h0000_0104, SKIP_FALLTHRU},
      '{ROW_FIXED,   MODE_CLASSIC, 32'h0000_0100, 32'h0000_0200, FRESH_INSTALL},
      '{ROW_PREDICT, MODE_CLASSIC, 32'h0000_0100, 32'h0000_0200, '0},
      '{ROW_PREDICT, MODE_CLASSIC, 32'h0000_0100, 32'h0000_0104, '0},
      '{ROW_PREDICT, MODE_CLASSIC, 32'h0000_0100, 32'h0000_0300, '0},
      '{ROW_PREDICT, MODE_CLASSIC, 32'h0000_0100, 32'h0000_0104, '0},
      '{ROW_PREDICT, MODE_CLASSIC, 32'h0000_0100, 32'h0000_0104, '0},
      '{ROW_PREDICT, MODE_CLASSIC, 32'h0000_0100, 32'h0000_0104, '0},
      '{ROW_PREDICT, MODE_CLASSIC, 32'h0000_0100, 32'h0000_0104, '0},
      '{ROW_PREDICT, MODE_CLASSIC, 32'h0000_0100, 32'h0000_0500, '0},
      // same index, different address: evict
      '{ROW_FIXED,   MODE_CLASSIC, 32'h0000_1100, 32'h0000_0040, EVICT_INSTALL},
      // address zero installs but stays empty
      '{ROW_FIXED,   MODE_CLASSIC, 32'h0000_0000, 32'h0000_0000, FRESH_INSTALL},
      '{ROW_FIXED,   MODE_CLASSIC, 32'h0000_0000, 32'h0000_0004, SKIP_FALLTHRU},
      // fall-through wraps around the top of the address space
      '{ROW_PREDICT, MODE_CLASSIC, 32'hFFFF_FFFC, 32'h0000_0000, '0},
      '{ROW_PREDICT, MODE_CLASSIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0},
      '{ROW_PREDICT, MODE_CLASSIC, 32'hFFFF_FFFF, 32'h0000_0003, '0},
      '{ROW_PREDICT, MODE_SPARE,   32'h0000_4000, 32'h0000_4100, '0},
      '{ROW_PREDICT, MODE_SPARE,   32'h0000_4000, 32'h0000_4004, '0},
      '{ROW_PREDICT, MODE_A,       32'h0000_2000, 32'h0000_0000, '0},
      '{ROW_PREDICT, MODE_A,       32'h0000_2000, 32'h0000_2004, '0},
      '{ROW_PREDICT, MODE_A,       32'h0000_2000, 32'h0000_2004, '0},
      '{ROW_PREDICT, MODE_A,       32'h0000_2000, 32'h0000_0000, '0},
      '{ROW_FIXED,   MODE_B,       32'h0000_3040, 32'h0000_3100, WEAK_INSTALL},
      '{ROW_PREDICT, MODE_B,       32'h0000_3040, 32'h0000_3100, '0},
      '{ROW_PREDICT, MODE_B,       32'h0000_3040, 32'h0000_3044, '0}
   };

   localparam logic [1:0] PHASE_MODES [7] = '{
      MODE_A, MODE_CLASSIC, MODE_SPARE, MODE_B, MODE_CLASSIC, MODE_A, MODE_B
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [ADDR_W-1:0] req_current_pc = '0;
   logic [ADDR_W-1:0] req_next_pc = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_hit;
   logic              rsp_predicted_taken;
   logic              rsp_correct;
   logic              rsp_wrong_target;
   logic              rsp_taken;
   logic              rsp_installed;
   logic              rsp_collision;
   logic [PRED_W-1:0] rsp_prediction_after;
   logic              csr_wr_en = 1'b0;
   logic [1:0]        csr_wr_data = '0;

   // shadow of the buffer contents and the selected machine
   logic [ADDR_W-1:0] btb_addr [DEPTH] = '{default: '0};
   logic [ADDR_W-1:0] btb_dest [DEPTH] = '{default: '0};
   logic [PRED_W-1:0] btb_pred [DEPTH] = '{default: '0};
   logic [1:0]        active_mode = MODE_CLASSIC;

   logic [ADDR_W-1:0] branch_pc [POOL];
   logic [ADDR_W-1:0] branch_dest [POOL];

   btb_outcome_type pending_outcomes [$];
   int unsigned     transfers_in = 0;
   int unsigned     results_seen = 0;
   int unsigned     mismatches = 0;

   branch_target_buffer_predictor dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_current_pc       (req_current_pc),
      .req_next_pc          (req_next_pc),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_hit              (rsp_hit),
      .rsp_predicted_taken  (rsp_predicted_taken),
      .rsp_correct          (rsp_correct),
      .rsp_wrong_target     (rsp_wrong_target),
      .rsp_taken            (rsp_taken),
      .rsp_installed        (rsp_installed),
      .rsp_collision        (rsp_collision),
      .rsp_prediction_after (rsp_prediction_after),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [PRED_W-1:0] step_counter(input logic [1:0] mode,
                                                      input logic [PRED_W-1:0] old,
                                                      input logic went_taken);
      logic [PRED_W-1:0] upd;
      if (went_taken) begin
         case (old)
            PRED_TAKEN, PRED_WEAK_TAKEN: upd = PRED_TAKEN;
            PRED_WEAK_NOT: upd = (mode == MODE_B) ? PRED_TAKEN : PRED_WEAK_TAKEN;
            default: upd = PRED_WEAK_NOT;
         endcase
      end else begin
         case (old)
            PRED_TAKEN: upd = PRED_WEAK_TAKEN;
            PRED_WEAK_TAKEN: upd = (mode == MODE_A) ? PRED_NOT : PRED_WEAK_NOT;
            default: upd = PRED_NOT;
         endcase
      end
      return upd;
   endfunction

   // resolve one branch against the shadow buffer and update it
   function automatic btb_outcome_type resolve_branch(input logic [ADDR_W-1:0] cur,
                                                      input logic [ADDR_W-1:0] nxt);
      int unsigned       idx;
      logic [ADDR_W-1:0] fall;
      logic [PRED_W-1:0] old;
      btb_outcome_type   o;
      o = '0;
      idx = (cur >> 2) % DEPTH;
      fall = cur + PC_STEP;
      if (btb_addr[idx] != '0 && btb_addr[idx] == cur) begin
         old = btb_pred[idx];
         o.hit = 1'b1;
         o.predicted_taken = (old == PRED_TAKEN || old == PRED_WEAK_TAKEN);
         if (o.predicted_taken) begin
            if (nxt == btb_dest[idx]) begin
               o.correct = 1'b1;
               o.taken = 1'b1;
            end else if (nxt != fall) begin
               o.wrong_target = 1'b1;
               o.taken = 1'b1;
               btb_dest[idx] = nxt;
            end
         end else if (nxt == fall) begin
            o.correct = 1'b1;
         end else begin
            o.taken = 1'b1;
         end
         btb_pred[idx] = step_counter(active_mode, old, o.taken);
      end else if (nxt != fall) begin
         o.installed = 1'b1;
         o.taken = 1'b1;
         o.collision = (btb_addr[idx] != '0);
         btb_addr[idx] = cur;
         btb_dest[idx] = nxt;
         btb_pred[idx] = (active_mode == MODE_B) ? PRED_WEAK_TAKEN : PRED_TAKEN;
      end
      o.prediction_after = btb_pred[idx];
      return o;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                  input logic [ADDR_W-1:0] want);
      mismatches++;
      if (mismatches <= REPORT_CAP)
         $display("mismatch on result %0d: %s got %0h expected %0h",
                  results_seen, what, got, want);
   endtask

   task automatic compare_field(input string what, input logic [PRED_W-1:0] got,
                                input logic [PRED_W-1:0] want);
      if (got !== want)
         report_mismatch(what, ADDR_W'(got), ADDR_W'(want));
   endtask

   // drain everything in flight, then write the machine select
   task automatic set_mode(input logic [1:0] mode);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      active_mode = mode;
   endtask

   task automatic offer_branch(input logic [ADDR_W-1:0] cur, input logic [ADDR_W-1:0] nxt,
                               input logic fixed, input btb_outcome_type fixed_res);
      int unsigned     gap;
      btb_outcome_type want;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_current_pc <= cur;
      req_next_pc <= nxt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = resolve_branch(cur, nxt);
      if (fixed)
         want = fixed_res;
      pending_outcomes.push_back(want);
      transfers_in++;
   endtask

   task automatic refresh_branches(input bit all);
      for (int k = 0; k < POOL; k++) begin
         if (all || $urandom_range(0, 1) == 1) begin
            branch_pc[k] = $urandom;
            // crowd the pool onto a few indexes so entries keep evicting each other
            branch_pc[k][11:2] = 10'($urandom_range(0, 7));
            branch_dest[k] = $urandom;
         end
      end
   endtask

   task automatic draw_branch(output logic [ADDR_W-1:0] cur, output logic [ADDR_W-1:0] nxt);
      int unsigned r;
      int unsigned s;
      int unsigned k;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         k = $urandom_range(0, POOL - 1);
         s = $urandom_range(0, 99);
         cur = branch_pc[k];
         if (s < 40) begin
            nxt = branch_dest[k];
         end else if (s < 70) begin
            nxt = cur + PC_STEP;
         end else if (s < 90) begin
            nxt = $urandom;
            if ($urandom_range(0, 1) == 1)
               branch_dest[k] = nxt;
         end else begin
            nxt = $urandom;
         end
      end else if (r < 95) begin
         cur = $urandom;
         nxt = ($urandom_range(0, 1) == 1) ? cur + PC_STEP : $urandom;
      end else begin
         cur = '0;
         nxt = ($urandom_range(0, 1) == 1) ? PC_STEP : $urandom;
      end
   endtask

   // response side: random stalls, plus one long hold-off to back the block up
   initial begin
      int unsigned r;
      bit          held_off;
      held_off = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (!held_off && transfers_in >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (r < 40) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else if (r < 45) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(50, 150)) @(posedge clock);
         end else if (r < 85) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else if (r < 97) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(4, 12)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      btb_outcome_type got;
      btb_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_hit, rsp_predicted_taken, rsp_correct, rsp_wrong_target, rsp_taken,
                 rsp_installed, rsp_collision, rsp_prediction_after};
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected transfer", ADDR_W'(got), '0);
         end else begin
            want = pending_outcomes.pop_front();
            compare_field("hit", PRED_W'(got.hit), PRED_W'(want.hit));
            compare_field("predicted_taken", PRED_W'(got.predicted_taken),
                          PRED_W'(want.predicted_taken));
            compare_field("correct", PRED_W'(got.correct), PRED_W'(want.correct));
            compare_field("wrong_target", PRED_W'(got.wrong_target),
                          PRED_W'(want.wrong_target));
            compare_field("taken", PRED_W'(got.taken), PRED_W'(want.taken));
            compare_field("installed", PRED_W'(got.installed), PRED_W'(want.installed));
            compare_field("collision", PRED_W'(got.collision), PRED_W'(want.collision));
            compare_field("prediction_after", got.prediction_after, want.prediction_after);
         end
         results_seen++;
      end
   end

   initial begin
      logic [ADDR_W-1:0] cur;
      logic [ADDR_W-1:0] nxt;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_PLAN[i]) begin
         if (DIRECTED_PLAN[i].mode != active_mode)
            set_mode(DIRECTED_PLAN[i].mode);
         offer_branch(DIRECTED_PLAN[i].cur, DIRECTED_PLAN[i].nxt,
                      DIRECTED_PLAN[i].kind == ROW_FIXED, DIRECTED_PLAN[i].res);
      end

      refresh_branches(1'b1);
      foreach (PHASE_MODES[p]) begin
         set_mode(PHASE_MODES[p]);
         refresh_branches(1'b0);
         repeat (ITEMS_PER_PHASE) begin
            draw_branch(cur, nxt);
            offer_branch(cur, nxt, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      // catch anything that trails the last expected transfer
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
